@@ hdl/row_column_profile_averager_assert.svh @@
// Assertion macros shared by the row/column profile averager RTL.
`ifndef ROW_COLUMN_PROFILE_AVERAGER_ASSERT_SVH
`define ROW_COLUMN_PROFILE_AVERAGER_ASSERT_SVH

`ifndef SYNTHESIS

`define RCPA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define RCPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define RCPA_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define RCPA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/rcpa_pkg.sv @@
// Types and constants of the row/column profile averager.
package rcpa_pkg;

    localparam int PIXEL_W = 16;
    localparam int SUM_W   = 24;
    localparam int POS_W   = 8;
    localparam int CFG_W   = 9;
    localparam int CFG_IDX_W = 1;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_PIXEL_BITS = 16;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = CFG_W'(200);
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = CFG_W'(100);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_index;

    typedef enum logic {
        KIND_COLUMN = 1'b0,
        KIND_ROW    = 1'b1
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ADD  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

@@ hdl/rcpa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rcpa_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/rcpa_div.sv @@
// Restoring divider, one quotient bit per cycle.
module rcpa_div #(
    parameter int DIVIDEND_W = 24,
    parameter int DIVISOR_W  = 9
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic [DIVIDEND_W-1:0] o_quotient,
    output rcpa_pkg::t_div_status o_status
);
    import rcpa_pkg::*;

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_divisor;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W+1:0]  diff;

    assign shifted = {r_rem, r_quo[DIVIDEND_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CNT_W'(DIVIDEND_W - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt     <= '0;
            r_rem     <= '0;
            r_quo     <= i_dividend;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (!diff[DIVISOR_W+1]) begin
                r_rem <= diff[DIVISOR_W-1:0];
                r_quo <= {r_quo[DIVIDEND_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[DIVISOR_W-1:0];
                r_quo <= {r_quo[DIVIDEND_W-2:0], 1'b0};
            end
        end
    end

    assign o_quotient    = r_quo;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

endmodule

@@ hdl/row_column_profile_averager.sv @@
// Top level of the row/column projection profile averager.
//
// Pixels enter on the input channel (i_in_valid, o_in_stall, i_pixel) in
// row-major order. Each transaction updates the running row sum and the
// column sum of its column, kept in a RAM of MAX_WIDTH entries.
// A pixel that ends a row yields the row average (sum / frame_width); a
// pixel on the last row yields its column average (sum / frame_height).
// The last pixel of a frame yields the column entry, then the row entry.
// Results leave on the output channel (o_out_valid, i_out_stall) from an
// output register; the block takes no pixel until all results are taken.
// Each result goes through the shared 24-step divider and then waits in the
// output register while the receiver stalls; the divider sets the rate.
// Writing frame_width or frame_height (i_cfg_we, i_cfg_index, i_cfg_data)
// restarts the frame. Reset restores 200 x 100, clears the counters and
// the row sum; the column RAM needs no clearing since row 0 writes it.
`include "row_column_profile_averager_assert.svh"

module row_column_profile_averager #(
    parameter int MAX_WIDTH  = rcpa_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rcpa_pkg::DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = rcpa_pkg::DEF_PIXEL_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rcpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rcpa_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [rcpa_pkg::PIXEL_W-1:0]   i_pixel,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_profile_kind,
    output logic [rcpa_pkg::POS_W-1:0]     o_position,
    output logic [rcpa_pkg::PIXEL_W-1:0]   o_average,
    output logic                           o_last_of_item
);
    import rcpa_pkg::*;

    localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int DIV_W   = (DIM_W > CFG_W) ? DIM_W : CFG_W;
    localparam logic [PIXEL_W-1:0] PIX_MASK =
        (PIXEL_BITS >= PIXEL_W) ? {PIXEL_W{1'b1}} : PIXEL_W'((64'd1 << PIXEL_BITS) - 64'd1);

    t_state              r_state;
    t_state              n_state;
    logic [CFG_W-1:0]    r_cfg_width;
    logic [CFG_W-1:0]    r_cfg_height;
    logic [COL_W-1:0]    r_col_cnt;
    logic [ROW_W-1:0]    r_row_cnt;
    logic [SUM_W-1:0]    r_row_sum;
    t_kind               r_kind;
    logic [PIXEL_W-1:0]  r_pix;
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic                r_end_row;
    logic                r_last_row;
    logic                r_out_kind;
    logic [POS_W-1:0]    r_out_pos;
    logic [PIXEL_W-1:0]  r_out_avg;
    logic                r_out_last;

    logic [DIV_W-1:0]    cfg_w_ext;
    logic [DIV_W-1:0]    cfg_h_ext;
    logic [DIV_W-1:0]    w_eff;
    logic [DIV_W-1:0]    h_eff;
    logic [DIV_W-1:0]    col_cnt_ext;
    logic [DIV_W-1:0]    row_cnt_ext;
    logic [COL_W-1:0]    col_cur;
    logic [ROW_W-1:0]    row_cur;
    logic [DIV_W-1:0]    col_cur_ext;
    logic [DIV_W-1:0]    row_cur_ext;
    logic [DIV_W-1:0]    col_ext;
    logic [DIV_W-1:0]    row_ext;
    logic                in_acc;
    logic                out_acc;
    logic [SUM_W-1:0]    ram_rdata;
    logic [SUM_W-1:0]    pix_ext;
    logic [SUM_W-1:0]    colsum_new;
    logic [SUM_W-1:0]    row_sum_new;
    logic                row_div_next;
    logic                div_start;
    logic                div_col;
    logic [SUM_W-1:0]    div_dividend;
    logic [DIV_W-1:0]    div_divisor;
    logic [SUM_W-1:0]    div_quotient;
    t_div_status         div_stat;

    assign cfg_w_ext = DIV_W'(r_cfg_width);
    assign cfg_h_ext = DIV_W'(r_cfg_height);

    always_comb begin
        priority if (cfg_w_ext == '0) begin
            w_eff = DIV_W'(1);
        end else if (cfg_w_ext > DIV_W'(MAX_WIDTH)) begin
            w_eff = DIV_W'(MAX_WIDTH);
        end else begin
            w_eff = cfg_w_ext;
        end
        priority if (cfg_h_ext == '0) begin
            h_eff = DIV_W'(1);
        end else if (cfg_h_ext > DIV_W'(MAX_HEIGHT)) begin
            h_eff = DIV_W'(MAX_HEIGHT);
        end else begin
            h_eff = cfg_h_ext;
        end
    end

    assign col_cnt_ext = DIV_W'(r_col_cnt);
    assign row_cnt_ext = DIV_W'(r_row_cnt);
    assign col_cur     = (col_cnt_ext >= w_eff) ? '0 : r_col_cnt;
    assign row_cur     = (row_cnt_ext >= h_eff) ? '0 : r_row_cnt;
    assign col_cur_ext = DIV_W'(col_cur);
    assign row_cur_ext = DIV_W'(row_cur);
    assign col_ext     = DIV_W'(r_col);
    assign row_ext     = DIV_W'(r_row);

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    assign pix_ext     = SUM_W'(r_pix);
    assign colsum_new  = ((r_row == '0) ? '0 : ram_rdata) + pix_ext;
    assign row_sum_new = r_row_sum + pix_ext;

    assign row_div_next = out_acc && (r_kind == KIND_COLUMN) && r_end_row;
    assign div_col      = (r_state == S_ADD) && r_last_row;
    assign div_start    = ((r_state == S_ADD) && (r_last_row || r_end_row)) || row_div_next;

    always_comb begin
        priority if (div_col) begin
            div_dividend = colsum_new;
        end else if (r_state == S_ADD) begin
            div_dividend = row_sum_new;
        end else begin
            div_dividend = r_row_sum;
        end
        div_divisor = div_col ? h_eff : w_eff;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_ADD;
            end
            S_ADD: begin
                n_state = (r_last_row || r_end_row) ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (div_stat.done) n_state = S_OUT;
            end
            S_OUT: begin
                if (out_acc) n_state = row_div_next ? S_DIV : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg_width  <= RST_FRAME_WIDTH;
            r_cfg_height <= RST_FRAME_HEIGHT;
            r_col_cnt    <= '0;
            r_row_cnt    <= '0;
            r_row_sum    <= '0;
            r_kind       <= KIND_COLUMN;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_FRAME_WIDTH:  r_cfg_width  <= i_cfg_data;
                    CFG_FRAME_HEIGHT: r_cfg_height <= i_cfg_data;
                    default: ;
                endcase
                r_col_cnt <= '0;
                r_row_cnt <= '0;
                r_row_sum <= '0;
            end
            if (r_state == S_ADD) begin
                r_kind <= r_last_row ? KIND_COLUMN : KIND_ROW;
                if (r_end_row) begin
                    r_col_cnt <= '0;
                    r_row_cnt <= r_last_row ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col_cnt <= r_col + COL_W'(1);
                    r_row_cnt <= r_row;
                end
                r_row_sum <= (r_end_row && !r_last_row) ? '0 : row_sum_new;
            end
            if (row_div_next) begin
                r_row_sum <= '0;
                r_kind    <= KIND_ROW;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pix      <= i_pixel & PIX_MASK;
            r_col      <= col_cur;
            r_row      <= row_cur;
            r_end_row  <= (col_cur_ext == (w_eff - DIV_W'(1)));
            r_last_row <= (row_cur_ext == (h_eff - DIV_W'(1)));
        end
        if ((r_state == S_DIV) && div_stat.done) begin
            r_out_kind <= r_kind;
            r_out_pos  <= (r_kind == KIND_COLUMN) ? col_ext[POS_W-1:0] : row_ext[POS_W-1:0];
            r_out_avg  <= div_quotient[PIXEL_W-1:0];
            r_out_last <= (r_kind == KIND_ROW) || !r_end_row;
        end
    end

    rcpa_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_ADD),
        .i_waddr (r_col),
        .i_wdata (colsum_new),
        .i_raddr (col_cur),
        .o_rdata (ram_rdata)
    );

    rcpa_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_quotient),
        .o_status   (div_stat)
    );

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = (r_state == S_OUT);
    assign o_profile_kind = r_out_kind;
    assign o_position     = r_out_pos;
    assign o_average      = r_out_avg;
    assign o_last_of_item = r_out_last;

    `RCPA_ASSERT_NEXT(a_accept_to_add, i_clk, i_rst_n, in_acc, r_state == S_ADD)
    `RCPA_ASSERT_IMPL(a_done_in_div, i_clk, i_rst_n, div_stat.done, r_state == S_DIV)
    `RCPA_ASSERT_IMPL(a_column_on_last_row, i_clk, i_rst_n, o_out_valid && (o_profile_kind == KIND_COLUMN), r_last_row)
    `RCPA_ASSERT_IMPL(a_partial_is_column, i_clk, i_rst_n, o_out_valid && !o_last_of_item, (o_profile_kind == KIND_COLUMN) && r_end_row)

endmodule

@@ test/row_column_profile_averager_tb.sv @@
// Self-checking testbench of the row/column profile averager: directed table, random frames.
module row_column_profile_averager_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcpa_pkg::*;

    localparam int DIR_LEN     = 25;
    localparam int RAND_ITEMS  = 1250;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYC  = 8;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  pos;
        logic [15:0] avg;
        logic        last_flag;
    } t_profile;

    typedef struct packed {
        logic        is_cfg;
        t_cfg_index  idx;
        logic [8:0]  cfg_val;
        logic [15:0] pix;
        logic [1:0]  n_typed;
        t_profile    lead;
        t_profile    trail;
    } t_step;

    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_PERIODIC,
        STALL_LONG
    } t_stall_mode;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic [PIXEL_W-1:0]   i_pixel     = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_profile_kind;
    logic [POS_W-1:0]     o_position;
    logic [PIXEL_W-1:0]   o_average;
    logic                 o_last_of_item;

    row_column_profile_averager dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pixel        (i_pixel),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_profile_kind (o_profile_kind),
        .o_position     (o_position),
        .o_average      (o_average),
        .o_last_of_item (o_last_of_item)
    );

    t_step directed_steps [DIR_LEN] = '{
        '{1'b0, CFG_FRAME_WIDTH,  9'd0, 16'hFFFF, 2'd0, '0, '0},
        '{1'b0, CFG_FRAME_WIDTH,  9'd0, 16'h0000, 2'd0, '0, '0},
        '{1'b0, CFG_FRAME_WIDTH,  9'd0, 16'h8001, 2'd0, '0, '0},
        '{1'b1, CFG_FRAME_WIDTH,  9'd0, 16'h0000, 2'd0, '0, '0},
        '{1'b1, CFG_FRAME_HEIGHT, 9'd0, 16'h0000, 2'd0, '0, '0},
        '{1'b0, CFG_FRAME_WIDTH,  9'd0, 16'hFFFF, 2'd2,
          '{KIND_COLUMN, 8'd0, 16'hFFFF, 1'b0}, '{KIND_ROW, 8'd0, 16'hFFFF, 1'b1}},
        '{1'b0, CFG_FRAME_WIDTH,  9'd0, 16'h0000, 2'd2,
          '{KIND_COLUMN, 8'd0, 16'h0000, 1'b0}, '{KIND_ROW, 8'd0, 16'h0000, 1'b1}},
        '{1'b1, CFG_FRAME_WIDTH,  9'd2, 16'h0000, 2'd0, '0, '0},
        '{1'b1, CFG_FRAME_HEIGHT, 9'd1, 16'h0000, 2'd0, '0, '0},
        '{1'b0, CFG_FRAME_WIDTH,  9'd0, 16'hFFFF, 2'd1,
          '{KIND_COLUMN, 8'd0, 16'hFFFF, 1'b1}, '0},
        '{1'b0, CFG_FRAME_WIDTH,  9'd0, 16'hFFFF, 2'd2,
          '{KIND_COLUMN, 8'd1, 16'hFFFF, 1'b0}, '{KIND_ROW, 8'd0, 16'hFFFF, 1'b1}},
        '{1'b1, CFG_FRAME_WIDTH,  9'd3, 16'h0000, 2'd0, '0, '0},
        '{1'b1, CFG_FRAME_HEIGHT, 9'd2, 16'h0000, 2'd0, '0, '0},
        '{1'b0, CFG_FRAME_WIDTH,  9'd0, 16'h0001, 2'd0, '0, '0},
        '{1'b0, CFG_FRAME_WIDTH,  9'd0, 16'hFFFF, 2'd0, '0, '0},
        '{1'b0, CFG_FRAME_WIDTH,  9'd0, 16'h5555, 2'd0, '0, '0},
        '{1'b0, CFG_FRAME_WIDTH,  9'd0, 16'hAAAA, 2'd0, '0, '0},
        '{1'b0, CFG_FRAME_WIDTH,  9'd0, 16'h0000, 2'd0, '0, '0},
        '{1'b0, CFG_FRAME_WIDTH,  9'd0, 16'h7FFF, 2'd0, '0, '0},
        '{1'b1, CFG_FRAME_WIDTH,  9'd1, 16'h0000, 2'd0, '0, '0},
        '{1'b1, CFG_FRAME_HEIGHT, 9'd3, 16'h0000, 2'd0, '0, '0},
        '{1'b0, CFG_FRAME_WIDTH,  9'd0, 16'hFFFF, 2'd0, '0, '0},
        '{1'b0, CFG_FRAME_WIDTH,  9'd0, 16'hFFFF, 2'd0, '0, '0},
        '{1'b0, CFG_FRAME_WIDTH,  9'd0, 16'hFFFE, 2'd0, '0, '0},
        '{1'b0, CFG_FRAME_WIDTH,  9'd0, 16'h1234, 2'd0, '0, '0}
    };

    logic [8:0]  width_setting  = RST_FRAME_WIDTH;
    logic [8:0]  height_setting = RST_FRAME_HEIGHT;
    logic [23:0] col_total [DEF_MAX_WIDTH];
    logic [23:0] row_total = '0;
    int          col_at = 0;
    int          row_at = 0;

    t_profile awaited_profiles [$];
    int       mismatch_count = 0;
    int       burst_left = 0;
    int       quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int active_dim(input logic [8:0] v, input int max_dim);
        if (v == 0) begin
            return 1;
        end
        if (v > max_dim) begin
            return max_dim;
        end
        return int'(v);
    endfunction

    function automatic int accumulate_pixel(input logic [15:0] pix, output t_profile lead,
                                            output t_profile trail);
        int       w;
        int       h;
        int       n;
        logic     row_end;
        logic     last_row;
        t_profile col_entry;
        t_profile row_entry;
        w = active_dim(width_setting, DEF_MAX_WIDTH);
        h = active_dim(height_setting, DEF_MAX_HEIGHT);
        if (col_at >= w) begin
            col_at = 0;
        end
        if (row_at >= h) begin
            row_at = 0;
        end
        row_end  = (col_at == w - 1);
        last_row = (row_at == h - 1);
        if (row_at == 0) begin
            col_total[col_at] = 24'(pix);
        end else begin
            col_total[col_at] = col_total[col_at] + 24'(pix);
        end
        row_total = row_total + 24'(pix);
        col_entry = '{KIND_COLUMN, 8'(col_at), 16'(col_total[col_at] / 24'(h)), !row_end};
        row_entry = '{KIND_ROW, 8'(row_at), 16'(row_total / 24'(w)), 1'b1};
        lead  = '0;
        trail = '0;
        n = 0;
        if (last_row) begin
            lead = col_entry;
            n = 1;
        end
        if (row_end) begin
            if (n == 0) begin
                lead = row_entry;
            end else begin
                trail = row_entry;
            end
            n++;
            row_total = '0;
            col_at = 0;
            row_at = last_row ? 0 : row_at + 1;
        end else begin
            col_at++;
        end
        return n;
    endfunction

    task automatic send_pixel(input logic [15:0] pix, input int n_typed,
                              input t_profile typed_lead, input t_profile typed_trail);
        t_profile lead;
        t_profile trail;
        int       n;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        n = accumulate_pixel(pix, lead, trail);
        if (n_typed != 0) begin
            n = n_typed;
            lead = typed_lead;
            trail = typed_trail;
        end
        if (n > 0) begin
            awaited_profiles.push_back(lead);
        end
        if (n > 1) begin
            awaited_profiles.push_back(trail);
        end
        i_in_valid <= 1'b1;
        i_pixel <= pix;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic settle_block();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (awaited_profiles.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_index idx, input logic [8:0] value);
        settle_block();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_FRAME_WIDTH) begin
            width_setting = value;
        end else begin
            height_setting = value;
        end
        row_total = '0;
        col_at = 0;
        row_at = 0;
    endtask

    function automatic void report_field(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatch_count++;
    endfunction

    always @(posedge i_clk) begin
        t_profile want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_profiles.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual %0h %0h %0h %0h",
                         $time, o_profile_kind, o_position, o_average, o_last_of_item);
                mismatch_count++;
            end else begin
                want = awaited_profiles.pop_front();
                if (want.kind !== t_kind'(o_profile_kind)) begin
                    report_field("profile_kind", 16'(want.kind), 16'(o_profile_kind));
                end
                if (want.pos !== o_position) begin
                    report_field("position", 16'(want.pos), 16'(o_position));
                end
                if (want.avg !== o_average) begin
                    report_field("average", want.avg, o_average);
                end
                if (want.last_flag !== o_last_of_item) begin
                    report_field("last_of_item", 16'(want.last_flag), 16'(o_last_of_item));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_stall_mode mode;
        int          mode_left;
        int          run_left;
        int          tick;
        if (mode_left <= 0) begin
            mode = t_stall_mode'($urandom_range(0, 3));
            mode_left = $urandom_range(50, 400);
        end
        mode_left--;
        tick++;
        case (mode)
            STALL_NONE: begin
                i_out_stall <= 1'b0;
            end
            STALL_COIN: begin
                i_out_stall <= 1'($urandom_range(0, 1));
            end
            STALL_PERIODIC: begin
                i_out_stall <= (tick % 5) < 2;
            end
            default: begin
                if (run_left <= 0) begin
                    i_out_stall <= ~i_out_stall;
                    run_left = $urandom_range(1, 20);
                end
                run_left--;
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        int          fed;
        int          phase;
        int          frame;
        int          count;
        logic [8:0]  wv;
        logic [8:0]  hv;
        logic [15:0] pix;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_LEN; k++) begin
            if (directed_steps[k].is_cfg) begin
                write_register(directed_steps[k].idx, directed_steps[k].cfg_val);
            end else begin
                send_pixel(directed_steps[k].pix, int'(directed_steps[k].n_typed),
                           directed_steps[k].lead, directed_steps[k].trail);
            end
        end

        fed = 0;
        phase = 0;
        while (fed < RAND_ITEMS) begin
            if (phase == 0) begin
                wv = 9'd256;
                hv = 9'd1;
            end else if (phase == 1) begin
                wv = 9'd1;
                hv = 9'd511;
            end else if (phase == 2) begin
                wv = 9'd300;
                hv = 9'd0;
            end else if ($urandom_range(0, 5) == 0) begin
                wv = 9'($urandom_range(10, 48));
                hv = 9'($urandom_range(1, 3));
            end else begin
                wv = 9'($urandom_range(0, 9));
                hv = 9'($urandom_range(0, 9));
            end
            if ($urandom_range(0, 1)) begin
                write_register(CFG_FRAME_WIDTH, wv);
                write_register(CFG_FRAME_HEIGHT, hv);
            end else begin
                write_register(CFG_FRAME_HEIGHT, hv);
                write_register(CFG_FRAME_WIDTH, wv);
            end
            frame = active_dim(wv, DEF_MAX_WIDTH) * active_dim(hv, DEF_MAX_HEIGHT);
            count = (phase < 3) ? frame
                                : frame * $urandom_range(1, 3) + $urandom_range(0, frame - 1);
            for (int k = 0; (k < count) && (fed < RAND_ITEMS); k++) begin
                case ($urandom_range(0, 7))
                    0: pix = 16'h0000;
                    1: pix = 16'hFFFF;
                    2: pix = 16'($urandom_range(0, 15));
                    3: pix = 16'hFFFF - 16'($urandom_range(0, 15));
                    default: pix = 16'($urandom);
                endcase
                send_pixel(pix, 0, '0, '0);
                fed++;
            end
            phase++;
        end

        settle_block();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
